// ----- src/assert_macros.svh -----
// assertion helpers for the walker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/idw_pkg.sv -----
// ----------------------------------------------------------------------------
// idw_pkg
// types, constants and codes shared by the image directory walker
// ----------------------------------------------------------------------------
package idw_pkg;

  localparam int unsigned POS_W = 28;
  localparam int unsigned LIM_W = 17;
  localparam logic [POS_W-1:0] MIN_IMAGE = 28'h5c;
  localparam logic [15:0] REC_MIN = 16'h1c;
  localparam logic [15:0] REC_FILE = 16'h20;
  localparam logic [15:0] TYPE_MASK = 16'hf000;
  localparam logic [15:0] TYPE_DIR = 16'h4000;
  localparam logic [15:0] TYPE_LNK = 16'ha000;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 17'd100000;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_MEMBER = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ERR_SIGNATURE = 4'd0,
    ERR_FLAGS = 4'd1,
    ERR_SIZE = 4'd2,
    ERR_DIROFFSET = 4'd3,
    ERR_RECSIZE = 4'd4,
    ERR_SHORT = 4'd5,
    ERR_RANGE = 4'd6,
    ERR_EMPTYNAME = 4'd7,
    ERR_LIMIT = 4'd8,
    ERR_NOTERM = 4'd9,
    ERR_NOMEMBERS = 4'd10,
    ERR_LENGTH = 4'd11
  } err_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP = 3'd1,
    PH_FIXED = 3'd2,
    PH_NAME = 3'd3,
    PH_TAIL = 3'd4
  } phase_t;

  typedef enum logic [0:0] {
    REG_IMAGE_LENGTH = 1'b0,
    REG_MEMBER_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic end_of_image;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] name_char;
    logic [26:0] entry_offset;
    logic [31:0] member_offset;
    logic [31:0] member_size;
    logic [15:0] member_mode;
    logic [31:0] member_mtime;
    logic [15:0] name_count;
    logic [3:0] error_code;
    logic run_end;
  } out_word_t;

  // what the front hands to the back for one byte: up to two results
  typedef struct packed {
    logic [1:0] count;
    out_word_t first;
    out_word_t second;
  } job_t;

  function automatic logic [7:0] sig_char(input logic [2:0] i);
    case (i)
      3'd0: sig_char = 8'h69;
      3'd1: sig_char = 8'h6d;
      3'd2: sig_char = 8'h61;
      3'd3: sig_char = 8'h67;
      3'd4: sig_char = 8'h65;
      3'd5: sig_char = 8'h66;
      3'd6: sig_char = 8'h73;
      default: sig_char = 8'h00;
    endcase
  endfunction

endpackage

// ----- src/image_directory_walker_core.sv -----
// ----------------------------------------------------------------------------
// image_directory_walker_core
// Walks the directory of a decompressed image filesystem streamed one byte
// per cycle. A byte is taken every cycle while the job queue has room; each
// byte yields zero, one or two result words, which are registered in a
// queue of four jobs that keeps one entry spare, so the input stalls once
// three jobs wait; words leave the queue one per cycle while the consumer
// does not stall. Sustained rate is one byte per cycle unless the consumer
// stalls or bytes that yield words arrive faster than words drain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module image_directory_walker_core #(
  parameter int unsigned QueueDepth = idw_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  idw_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output idw_pkg::out_word_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [31:0] cfg_data
);
  import idw_pkg::*;

  logic [POS_W-1:0] image_length;
  logic [LIM_W-1:0] member_limit;
  logic take, room, empty;
  job_t job;

  assign cfg_ready = 1'b1;
  assign in_stall = !room;
  assign take = in_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= '0;
      member_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_LENGTH: image_length <= cfg_data[POS_W-1:0];
        REG_MEMBER_LIMIT: member_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  idw_front u_front (
    .clk(clk), .rst(rst), .take(take), .in_word(in_data),
    .image_length(image_length), .member_limit(member_limit), .job(job)
  );

  idw_back #(.Depth(QueueDepth)) u_back (
    .clk(clk), .rst(rst), .push(take), .job(job), .room(room), .empty(empty),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_data)
  );

  `ASSERT_CLK(a_valid_empty, clk, rst, out_valid == !empty, "valid mismatch")

endmodule

// ----- src/idw_front.sv -----
// ----------------------------------------------------------------------------
// idw_front
// parses one image byte per cycle while take is high and produces the results that byte causes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module idw_front (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  idw_pkg::in_word_t in_word,
  input  logic [idw_pkg::POS_W-1:0] image_length,
  input  logic [idw_pkg::LIM_W-1:0] member_limit,
  output idw_pkg::job_t job
);
  import idw_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  phase_t walk_phase, walk_phase_next;
  logic [31:0] directory_start, directory_start_next;
  logic [POS_W-1:0] record_start, record_start_next;
  logic [POS_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] record_length, record_length_next;
  logic [15:0] mode_word, mode_word_next;
  logic [31:0] time_word, time_word_next;
  logic [31:0] data_offset_word, data_offset_word_next;
  logic [31:0] data_size_word, data_size_word_next;
  logic [15:0] name_bytes_seen, name_bytes_seen_next;
  logic [LIM_W-1:0] members_found, members_found_next;
  logic walk_closed, walk_closed_next;

  // compares on the held record fields
  logic [POS_W:0] next_rec;
  logic next_bad;
  logic [32:0] range_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      walk_phase <= PH_HEADER;
      directory_start <= '0;
      record_start <= '0;
      bytes_remaining <= '0;
      record_length <= '0;
      mode_word <= '0;
      time_word <= '0;
      data_offset_word <= '0;
      data_size_word <= '0;
      name_bytes_seen <= '0;
      members_found <= '0;
      walk_closed <= 1'b0;
    end else if (take) begin
      byte_position <= byte_position_next;
      walk_phase <= walk_phase_next;
      directory_start <= directory_start_next;
      record_start <= record_start_next;
      bytes_remaining <= bytes_remaining_next;
      record_length <= record_length_next;
      mode_word <= mode_word_next;
      time_word <= time_word_next;
      data_offset_word <= data_offset_word_next;
      data_size_word <= data_size_word_next;
      name_bytes_seen <= name_bytes_seen_next;
      members_found <= members_found_next;
      walk_closed <= walk_closed_next;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] off;
    logic [1:0] n;
    out_word_t r0, r1, w;
    logic [15:0] rl;
    logic [15:0] mw;
    logic [31:0] dsw;
    logic [31:0] d;
    logic [4:0] sh;
    logic fin;
    logic last_rec;
    logic [POS_W-1:0] at;
    logic do_start;
    logic [15:0] nb;

    b = in_word.data_byte;
    p = byte_position;
    off = p - record_start;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    w = '0;
    rl = record_length;
    mw = mode_word;
    dsw = data_size_word;
    d = directory_start;
    sh = 5'd0;
    fin = 1'b0;
    last_rec = 1'b0;
    at = '0;
    do_start = 1'b0;
    nb = name_bytes_seen;
    next_rec = {1'b0, record_start} + {{(POS_W-15){1'b0}}, record_length};
    next_bad = (next_rec > {1'b0, image_length}) ||
               (({1'b0, image_length} - next_rec) < {{(POS_W-15){1'b0}}, REC_MIN});
    range_room = {5'd0, image_length} - {1'b0, data_offset_word};

    byte_position_next = p + 1'b1;
    walk_phase_next = walk_phase;
    directory_start_next = directory_start;
    record_start_next = record_start;
    bytes_remaining_next = bytes_remaining;
    record_length_next = record_length;
    mode_word_next = mode_word;
    time_word_next = time_word;
    data_offset_word_next = data_offset_word;
    data_size_word_next = data_size_word;
    name_bytes_seen_next = name_bytes_seen;
    members_found_next = members_found;
    walk_closed_next = walk_closed;

    if (!walk_closed) begin
      if (in_word.end_of_image && ({1'b0, p} + 1'b1) != {1'b0, image_length}) begin
        fin = 1'b1;
        w = '0;
        w.result_kind = KIND_ERROR;
        w.error_code = ERR_LENGTH;
        r0 = w;
        n = 2'd1;
        walk_closed_next = 1'b1;
      end else if (walk_phase == PH_HEADER) begin
        if (p == '0 && image_length <= MIN_IMAGE) begin
          w.result_kind = KIND_ERROR;
          w.error_code = ERR_LENGTH;
          r0 = w;
          n = 2'd1;
          walk_closed_next = 1'b1;
        end else if (p < 28'd7) begin
          if (b != sig_char(p[2:0])) begin
            w.result_kind = KIND_ERROR;
            w.error_code = ERR_SIGNATURE;
            r0 = w;
            n = 2'd1;
            walk_closed_next = 1'b1;
          end
        end else if (p == 28'd7) begin
          if (b != 8'd0 && b != 8'd4) begin
            w.result_kind = KIND_ERROR;
            w.error_code = ERR_FLAGS;
            r0 = w;
            n = 2'd1;
            walk_closed_next = 1'b1;
          end
        end else if (p >= 28'd8 && p <= 28'd11) begin
          sh = {p[1:0], 3'b000};
          dsw = data_size_word | ({24'd0, b} << sh);
          data_size_word_next = dsw;
          if (p == 28'd11 && dsw != {4'd0, image_length}) begin
            w.result_kind = KIND_ERROR;
            w.error_code = ERR_SIZE;
            r0 = w;
            n = 2'd1;
            walk_closed_next = 1'b1;
          end
        end else if (p >= 28'd16 && p <= 28'd19) begin
          sh = {p[1:0], 3'b000};
          d = directory_start | ({24'd0, b} << sh);
          directory_start_next = d;
          if (p == 28'd19) begin
            if (d[31] || d < {4'd0, MIN_IMAGE} || d >= {4'd0, image_length}) begin
              w.result_kind = KIND_ERROR;
              w.error_code = ERR_DIROFFSET;
              r0 = w;
              n = 2'd1;
              walk_closed_next = 1'b1;
            end else if ((image_length - d[POS_W-1:0]) < {{(POS_W-16){1'b0}}, REC_MIN}) begin
              w.result_kind = KIND_ERROR;
              w.error_code = ERR_NOTERM;
              r0 = w;
              n = 2'd1;
              walk_closed_next = 1'b1;
            end else begin
              walk_phase_next = PH_SKIP;
            end
          end
        end
      end else if (walk_phase != PH_SKIP) begin
        if (walk_phase == PH_FIXED) begin
          if (off == '0) begin
            rl = {8'd0, b};
            record_length_next = rl;
          end else if (off == 28'd1) begin
            rl = {b, record_length[7:0]};
            record_length_next = rl;
            if (rl == 16'd0) begin
              walk_closed_next = 1'b1;
              if (members_found != '0) begin
                w.result_kind = KIND_DONE;
              end else begin
                w.result_kind = KIND_ERROR;
                w.error_code = ERR_NOMEMBERS;
              end
              r0 = w;
              n = 2'd1;
            end else if ({{(POS_W-16){1'b0}}, rl} > bytes_remaining || rl < REC_MIN) begin
              w.result_kind = KIND_ERROR;
              w.error_code = ERR_RECSIZE;
              r0 = w;
              n = 2'd1;
              walk_closed_next = 1'b1;
            end
          end else if (off == 28'd8) begin
            mode_word_next = {8'd0, b};
          end else if (off == 28'd9) begin
            mw = {b, mode_word[7:0]};
            mode_word_next = mw;
            if ((mw & TYPE_MASK) == TYPE_DIR || (mw & TYPE_MASK) == TYPE_LNK) begin
              walk_phase_next = PH_TAIL;
            end else if (record_length < REC_FILE) begin
              w.result_kind = KIND_ERROR;
              w.error_code = ERR_SHORT;
              r0 = w;
              n = 2'd1;
              walk_closed_next = 1'b1;
            end
          end else if (off >= 28'h14 && off <= 28'h17) begin
            sh = {off[1:0], 3'b000};
            time_word_next = time_word | ({24'd0, b} << sh);
          end else if (off >= 28'h18 && off <= 28'h1b) begin
            sh = {off[1:0], 3'b000};
            data_offset_word_next = data_offset_word | ({24'd0, b} << sh);
          end else if (off >= 28'h1c && off <= 28'h1f) begin
            sh = {off[1:0], 3'b000};
            dsw = data_size_word | ({24'd0, b} << sh);
            data_size_word_next = dsw;
            if (off == 28'h1f) begin
              if (data_offset_word > {4'd0, image_length} ||
                  {1'b0, dsw} > range_room) begin
                w.result_kind = KIND_ERROR;
                w.error_code = ERR_RANGE;
                r0 = w;
                n = 2'd1;
                walk_closed_next = 1'b1;
              end else if (record_length == REC_FILE) begin
                w.result_kind = KIND_ERROR;
                w.error_code = ERR_EMPTYNAME;
                r0 = w;
                n = 2'd1;
                walk_closed_next = 1'b1;
              end else begin
                walk_phase_next = PH_NAME;
              end
            end
          end
        end else if (walk_phase == PH_NAME) begin
          last_rec = (b == 8'd0) || ((off + 1'b1) == {{(POS_W-16){1'b0}}, record_length});
          if (b != 8'd0) begin
            nb = name_bytes_seen + 1'b1;
            name_bytes_seen_next = nb;
            if (members_found < member_limit) begin
              w = '0;
              w.result_kind = KIND_NAME;
              w.name_char = b;
              r0 = w;
              n = 2'd1;
            end
          end
          if (last_rec) begin
            walk_phase_next = PH_TAIL;
            w = '0;
            if (nb == 16'd0) begin
              w.result_kind = KIND_ERROR;
              w.error_code = ERR_EMPTYNAME;
              walk_closed_next = 1'b1;
            end else if (members_found >= member_limit) begin
              w.result_kind = KIND_ERROR;
              w.error_code = ERR_LIMIT;
              walk_closed_next = 1'b1;
            end else begin
              members_found_next = members_found + 1'b1;
              w.result_kind = KIND_MEMBER;
              w.entry_offset = record_start[26:0];
              w.member_offset = data_offset_word;
              w.member_size = data_size_word;
              w.member_mode = mode_word;
              w.member_mtime = time_word;
              w.name_count = nb;
            end
            if (n == 2'd0) r0 = w;
            else r1 = w;
            n = n + 1'b1;
          end
        end

        if (!walk_closed_next && off >= 28'h1b &&
            (off + 1'b1) == {{(POS_W-16){1'b0}}, rl}) begin
          if (next_bad) begin
            w = '0;
            w.result_kind = KIND_ERROR;
            w.error_code = ERR_NOTERM;
            if (n == 2'd2) n = 2'd1;
            if (n == 2'd0) r0 = w;
            else r1 = w;
            n = n + 1'b1;
            walk_closed_next = 1'b1;
          end else begin
            at = next_rec[POS_W-1:0];
            do_start = 1'b1;
          end
        end
      end

      if (!walk_closed_next && walk_phase_next == PH_SKIP &&
          ({1'b0, p} + 1'b1) == {1'b0, directory_start[POS_W-1:0]} &&
          directory_start[31:POS_W] == '0) begin
        at = directory_start[POS_W-1:0];
        do_start = 1'b1;
      end
      if (do_start) begin
        record_start_next = at;
        bytes_remaining_next = image_length - at;
        record_length_next = '0;
        mode_word_next = '0;
        time_word_next = '0;
        data_offset_word_next = '0;
        data_size_word_next = '0;
        name_bytes_seen_next = '0;
        walk_phase_next = PH_FIXED;
      end
      if (!walk_closed_next && in_word.end_of_image && n < 2'd2) begin
        w = '0;
        w.result_kind = KIND_ERROR;
        w.error_code = ERR_NOTERM;
        if (n == 2'd0) r0 = w;
        else r1 = w;
        n = n + 1'b1;
        walk_closed_next = 1'b1;
      end
    end

    if (n == 2'd1) r0.run_end = 1'b1;
    if (n == 2'd2) r1.run_end = 1'b1;
    if (fin) begin
      r0.run_end = 1'b1;
    end
    job.count = n;
    job.first = r0;
    job.second = r1;

    if (in_word.end_of_image) begin
      byte_position_next = '0;
      walk_phase_next = PH_HEADER;
      directory_start_next = '0;
      record_start_next = '0;
      bytes_remaining_next = '0;
      record_length_next = '0;
      mode_word_next = '0;
      time_word_next = '0;
      data_offset_word_next = '0;
      data_size_word_next = '0;
      name_bytes_seen_next = '0;
      members_found_next = '0;
      walk_closed_next = 1'b0;
    end
  end

  `ASSERT_NEXT(a_closed_quiet, clk, rst, take && walk_closed && !in_word.end_of_image,
               walk_closed, "walk reopened without end mark")
  `ASSERT_CLK(a_closed_no_out, clk, rst, !walk_closed || job.count == 2'd0,
              "closed walk produced results")
  `ASSERT_CLK(a_count_max, clk, rst, job.count != 2'd3, "more than two results")

endmodule

// ----- src/idw_back.sv -----
// ----------------------------------------------------------------------------
// idw_back
// queues jobs from the front and streams their results one word at a time
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module idw_back #(
  parameter int unsigned Depth = idw_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  idw_pkg::job_t job,
  output logic room,
  output logic empty,
  output logic out_valid,
  input  logic out_stall,
  output idw_pkg::out_word_t out_word
);
  import idw_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] fill;
  logic half;
  logic pop, advance, push_q;
  job_t head;

  assign push_q = push && job.count != 2'd0;
  assign head = mem[rd_ptr];
  assign empty = (fill == '0);
  // keep one slot spare so the input side never depends on the output side
  assign room = (fill < (AW+1)'(Depth - 1));
  assign out_valid = !empty;
  assign out_word = half ? head.second : head.first;
  assign advance = out_valid && !out_stall;
  assign pop = advance && (half || head.count == 2'd1);

  always_ff @(posedge clk) begin
    if (push_q) mem[wr_ptr] <= job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
      half <= 1'b0;
    end else begin
      if (push_q) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(push_q) - (AW+1)'(pop);
      if (pop) half <= 1'b0;
      else if (advance) half <= 1'b1;
    end
  end

  `ASSERT_CLK(a_no_overflow, clk, rst, !(push_q && fill == (AW+1)'(Depth)),
              "queue overflow")
  `ASSERT_CLK(a_half_two, clk, rst, !half || (!empty && head.count == 2'd2),
              "second half of a single result")

endmodule
